// ----- design/stli_pkg.sv -----
// ----------------------------------------------------------------------------
// Sorted table interpolator package
// Shared types, codes and field widths of the sorted interpolation table.
// ----------------------------------------------------------------------------
`default_nettype none

package stli_pkg;

   localparam int DATA_W   = 32;
   localparam int ENTRY_W  = 2 * DATA_W;
   localparam int PROD_W   = 2 * DATA_W;
   localparam int COUNT_W  = 5;
   localparam int STATUS_W = 2;
   localparam int RSP_W    = 40;
   localparam int DIV_STEPS = PROD_W;

   // Request kinds carried in the input tuser.
   localparam logic REQ_INSERT = 1'b0;
   localparam logic REQ_QUERY  = 1'b1;

   // Result status codes.
   localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_DUP   = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd3;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INS_RD,
      ST_INS_CMP,
      ST_SHF_RD,
      ST_SHF_WR,
      ST_QRY_RD,
      ST_QRY_CMP,
      ST_MAG,
      ST_MUL,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_SUM,
      ST_DONE
   } stli_state_type;

endpackage

`default_nettype wire

// ----- design/stli_table.sv -----
// ----------------------------------------------------------------------------
// Node table memory
// One write port and one read port with registered read data; each word
// holds a node as {value, key}.
// ----------------------------------------------------------------------------
`default_nettype none

module stli_table #(
   parameter int DEPTH = 16,
   parameter int AW    = 4
) (
   input  wire logic                       clock,
   input  wire logic                       wr_en,
   input  wire logic [AW-1:0]              wr_addr,
   input  wire logic [stli_pkg::ENTRY_W-1:0] wr_data,
   input  wire logic [AW-1:0]              rd_addr,
   output      logic [stli_pkg::ENTRY_W-1:0] rd_data
);
   import stli_pkg::*;

   logic [ENTRY_W-1:0] mem_ff [DEPTH];
   logic [ENTRY_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- design/stli_divider.sv -----
// ----------------------------------------------------------------------------
// Iterative unsigned divider
// Restoring division of a 64-bit dividend by a 32-bit divisor, one quotient
// bit per cycle. Done pulses for one cycle when the quotient is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module stli_divider (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [stli_pkg::PROD_W-1:0] dividend,
   input  wire logic [stli_pkg::DATA_W-1:0] divisor,
   output      logic                        done,
   output      logic [stli_pkg::PROD_W-1:0] quotient
);
   import stli_pkg::*;

   localparam int STEP_W = $clog2(DIV_STEPS);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [DATA_W-1:0] rem_ff, rem_in;
   logic [PROD_W-1:0] quo_ff, quo_in;
   logic [DATA_W-1:0] den_ff, den_in;

   logic [DATA_W:0]   rem_sh;
   logic [DATA_W:0]   rem_sub;
   logic              take;

   always_comb begin
      rem_sh  = {rem_ff, quo_ff[PROD_W-1]};
      take    = rem_sh >= {1'b0, den_ff};
      rem_sub = rem_sh - {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = '0;
         quo_in  = dividend;
         den_in  = divisor;
      end else if (busy_ff) begin
         // The partial remainder stays below the divisor, so 32 bits hold it.
         rem_in  = take ? rem_sub[DATA_W-1:0] : rem_sh[DATA_W-1:0];
         quo_in  = {quo_ff[PROD_W-2:0], take};
         step_in = step_ff + STEP_W'(1);
         if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      den_ff  <= den_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

// ----- design/sorted_table_linear_interpolator.sv -----
// ----------------------------------------------------------------------------
// Sorted table linear interpolator
// Keeps up to MAX_NODES (key, value) nodes in increasing key order and
// answers queries by linear interpolation in signed Q16.16.
// ----------------------------------------------------------------------------
// Usage: a request beat on req_ carries the kind in tuser (insert or query)
// and key and node value in tdata. Each request gives exactly one response
// beat on rsp_ with the result value, a status and the node count.
// An insert scans the table in node order, reading and then comparing each
// node, then shifts the larger nodes up by one place, reading and writing
// each one. A query scans in node order up to the segment, then forms the
// differences and the product and runs the bit-serial divider.
// One request is worked on at a time; req_tready is high only while idle.
// A finished response sits in an output register, so the next request can
// be accepted while the receiver stalls; its result then waits until the
// earlier beat is taken. Reset empties the table at once (the node count is
// cleared; table contents need no clearing) and drops any pending response.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_table_linear_interpolator #(
   parameter int MAX_NODES = 16
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   // Request channel.
   input  wire logic                      req_tvalid,
   output      logic                      req_tready,
   input  wire logic [63:0]               req_tdata,  // key[31:0], node_value[63:32]
   input  wire logic                      req_tuser,  // req_type[0]
   // Response channel.
   output      logic                      rsp_tvalid,
   input  wire logic                      rsp_tready,
   output      logic [stli_pkg::RSP_W-1:0] rsp_tdata  // result_value[31:0], status[33:32],
                                                     // node_count[38:34], zero[39]
);
   import stli_pkg::*;

   localparam int AW    = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam int CNT_W = $clog2(MAX_NODES + 1);
   localparam int SUM_W = 42;
   localparam logic [PROD_W-1:0] Q_LIMIT = PROD_W'(64'h100_0000_0000);
   localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(64'sh7FFF_FFFF);
   localparam logic signed [SUM_W-1:0] SUM_MIN = -SUM_W'(64'sh8000_0000);

   stli_state_type state_ff, state_in;

   logic [CNT_W-1:0]           count_ff, count_in;
   logic [CNT_W-1:0]           idx_ff, idx_in;
   logic [CNT_W-1:0]           pos_ff, pos_in;
   logic signed [DATA_W-1:0]   key_ff, key_in;
   logic signed [DATA_W-1:0]   val_ff, val_in;
   logic signed [DATA_W-1:0]   k0_ff, k0_in;
   logic signed [DATA_W-1:0]   v0_ff, v0_in;
   logic signed [DATA_W-1:0]   k1_ff, k1_in;
   logic signed [DATA_W-1:0]   v1_ff, v1_in;
   logic [DATA_W-1:0]          mdv_ff, mdv_in;
   logic [DATA_W-1:0]          mdk_ff, mdk_in;
   logic [DATA_W-1:0]          dp_ff, dp_in;
   logic                       neg_ff, neg_in;
   logic [PROD_W-1:0]          prod_ff, prod_in;
   logic signed [DATA_W-1:0]   res_ff, res_in;
   logic [STATUS_W-1:0]        stat_ff, stat_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]           rsp_data_ff, rsp_data_in;

   // Table and divider hookup.
   logic                       wr_en;
   logic [AW-1:0]              wr_addr;
   logic [ENTRY_W-1:0]         wr_data;
   logic [AW-1:0]              rd_addr;
   logic [ENTRY_W-1:0]         rd_data;
   logic                       div_start;
   logic                       div_done;
   logic [PROD_W-1:0]          div_quo;

   logic                       req_fire;
   logic                       out_free;
   logic signed [DATA_W-1:0]   rd_key;
   logic signed [DATA_W-1:0]   rd_val;
   logic                       at_end;
   logic                       at_last;
   logic                       is_full;
   logic [DATA_W:0]            dv;
   logic [DATA_W:0]            dk;
   logic [DATA_W:0]            dp;
   logic [40:0]                q_clamp;
   logic signed [SUM_W-1:0]    sum;
   logic [COUNT_W-1:0]         cnt_ext;

   stli_table #(
      .DEPTH (MAX_NODES),
      .AW    (AW)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   stli_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod_ff),
      .divisor  (dp_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign rd_key  = rd_data[DATA_W-1:0];
   assign rd_val  = rd_data[ENTRY_W-1:DATA_W];
   assign at_end  = (idx_ff == count_ff);
   assign at_last = (idx_ff == count_ff - CNT_W'(1));
   assign is_full = (count_ff == CNT_W'(MAX_NODES));

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_tuser == REQ_INSERT) begin
                  state_in = ST_INS_RD;
               end else if (count_ff == '0) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_QRY_RD;
               end
            end
         end
         ST_INS_RD: begin
            if (!at_end) begin
               state_in = ST_INS_CMP;
            end else if (is_full) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_SHF_RD;
            end
         end
         ST_INS_CMP: begin
            if (rd_key < key_ff) begin
               state_in = ST_INS_RD;
            end else if (rd_key == key_ff || is_full) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_SHF_RD;
            end
         end
         ST_SHF_RD: state_in = (idx_ff == pos_ff) ? ST_DONE : ST_SHF_WR;
         ST_SHF_WR: state_in = ST_SHF_RD;
         ST_QRY_RD: state_in = ST_QRY_CMP;
         ST_QRY_CMP: begin
            if (idx_ff == '0) begin
               state_in = (count_ff == CNT_W'(1)) ? ST_DONE : ST_QRY_RD;
            end else if (key_ff < rd_key || at_last) begin
               state_in = ST_MAG;
            end else begin
               state_in = ST_QRY_RD;
            end
         end
         ST_MAG:      state_in = ST_MUL;
         ST_MUL:      state_in = ST_DIV_GO;
         ST_DIV_GO:   state_in = ST_DIV_WAIT;
         ST_DIV_WAIT: state_in = div_done ? ST_SUM : ST_DIV_WAIT;
         ST_SUM:      state_in = ST_DONE;
         ST_DONE:     state_in = out_free ? ST_IDLE : ST_DONE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // Datapath and sequencer outputs.
   always_comb begin
      count_in  = count_ff;
      idx_in    = idx_ff;
      pos_in    = pos_ff;
      key_in    = key_ff;
      val_in    = val_ff;
      k0_in     = k0_ff;
      v0_in     = v0_ff;
      k1_in     = k1_ff;
      v1_in     = v1_ff;
      mdv_in    = mdv_ff;
      mdk_in    = mdk_ff;
      dp_in     = dp_ff;
      neg_in    = neg_ff;
      prod_in   = prod_ff;
      res_in    = res_ff;
      stat_in   = stat_ff;
      wr_en     = 1'b0;
      wr_addr   = idx_ff[AW-1:0];
      wr_data   = rd_data;
      rd_addr   = idx_ff[AW-1:0];
      div_start = 1'b0;

      dv = {v1_ff[DATA_W-1], v1_ff} - {v0_ff[DATA_W-1], v0_ff};
      dk = {key_ff[DATA_W-1], key_ff} - {k0_ff[DATA_W-1], k0_ff};
      dp = {k1_ff[DATA_W-1], k1_ff} - {k0_ff[DATA_W-1], k0_ff};

      q_clamp = (div_quo > Q_LIMIT) ? Q_LIMIT[40:0] : div_quo[40:0];
      sum = neg_ff ? (SUM_W'(v0_ff) - $signed({1'b0, q_clamp}))
                   : (SUM_W'(v0_ff) + $signed({1'b0, q_clamp}));

      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               key_in  = req_tdata[DATA_W-1:0];
               val_in  = req_tdata[ENTRY_W-1:DATA_W];
               idx_in  = '0;
               res_in  = '0;
               stat_in = STAT_OK;
               if (req_tuser == REQ_QUERY && count_ff == '0) begin
                  stat_in = STAT_EMPTY;
                  res_in  = {1'b1, {(DATA_W-1){1'b0}}};
               end
            end
         end
         ST_INS_RD: begin
            // Every node is below the new key: it goes after the last one.
            if (at_end) begin
               if (is_full) begin
                  stat_in = STAT_FULL;
               end else begin
                  pos_in = idx_ff;
                  idx_in = count_ff;
               end
            end
         end
         ST_INS_CMP: begin
            if (rd_key < key_ff) begin
               idx_in = idx_ff + CNT_W'(1);
            end else if (rd_key == key_ff) begin
               stat_in = STAT_DUP;
            end else if (is_full) begin
               stat_in = STAT_FULL;
            end else begin
               pos_in = idx_ff;
               idx_in = count_ff;
            end
         end
         ST_SHF_RD: begin
            if (idx_ff == pos_ff) begin
               wr_en    = 1'b1;
               wr_data  = {val_ff, key_ff};
               count_in = count_ff + CNT_W'(1);
            end else begin
               rd_addr = idx_ff[AW-1:0] - AW'(1);
            end
         end
         ST_SHF_WR: begin
            wr_en  = 1'b1;
            idx_in = idx_ff - CNT_W'(1);
         end
         ST_QRY_CMP: begin
            if (idx_ff == '0) begin
               res_in = rd_val;
               k0_in  = rd_key;
               v0_in  = rd_val;
               idx_in = CNT_W'(1);
            end else if (key_ff < rd_key || at_last) begin
               k1_in = rd_key;
               v1_in = rd_val;
            end else begin
               k0_in  = rd_key;
               v0_in  = rd_val;
               idx_in = idx_ff + CNT_W'(1);
            end
         end
         ST_MAG: begin
            mdv_in = dv[DATA_W] ? DATA_W'(-dv) : dv[DATA_W-1:0];
            mdk_in = dk[DATA_W] ? DATA_W'(-dk) : dk[DATA_W-1:0];
            dp_in  = dp[DATA_W-1:0];
            neg_in = dv[DATA_W] ^ dk[DATA_W];
         end
         ST_MUL: begin
            prod_in = PROD_W'(mdv_ff) * PROD_W'(mdk_ff);
         end
         ST_DIV_GO: begin
            div_start = 1'b1;
         end
         ST_SUM: begin
            if (sum > SUM_MAX) begin
               res_in = SUM_MAX[DATA_W-1:0];
            end else if (sum < SUM_MIN) begin
               res_in = SUM_MIN[DATA_W-1:0];
            end else begin
               res_in = sum[DATA_W-1:0];
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {1'b0, cnt_ext, stat_ff, res_ff};
            end
         end
         default: begin
         end
      endcase
   end

   // Report the low bits of the count, zero-filled when the count is narrow.
   assign cnt_ext = COUNT_W'(count_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff      <= idx_in;
      pos_ff      <= pos_in;
      key_ff      <= key_in;
      val_ff      <= val_in;
      k0_ff       <= k0_in;
      v0_ff       <= v0_in;
      k1_ff       <= k1_in;
      v1_ff       <= v1_in;
      mdv_ff      <= mdv_in;
      mdk_ff      <= mdk_in;
      dp_ff       <= dp_in;
      neg_ff      <= neg_in;
      prod_ff     <= prod_in;
      res_ff      <= res_in;
      stat_ff     <= stat_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

// ----- tb/sorted_table_linear_interpolator_tb.sv -----
// ----------------------------------------------------------------------------
// Sorted table linear interpolator testbench
// Streams insert and query requests into the block, predicts each response
// from a behavioral copy of the sorted node table, and checks every response
// beat field by field, with random idle cycles on both channels.
// ----------------------------------------------------------------------------
module sorted_table_linear_interpolator_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import stli_pkg::*;

   localparam int NODES = 16;
   localparam int RANDOM_ITEMS = 1500;
   localparam longint SUM_MAX = 64'sd2147483647;
   localparam longint SUM_MIN = -64'sd2147483648;
   localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;
   localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;

   typedef struct {
      logic              kind;
      logic signed [31:0] key;
      logic signed [31:0] value;
   } node_req_type;

   typedef struct {
      logic signed [31:0]  value;
      logic [STATUS_W-1:0] status;
      logic [COUNT_W-1:0]  count;
   } node_rsp_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [63:0]       req_tdata = '0;  // key[31:0], node_value[63:32]
   logic              req_tuser = 1'b0; // req_type[0]
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [RSP_W-1:0]  rsp_tdata;        // result_value[31:0], status[33:32],
                                        // node_count[38:34], zero[39]

   // Behavioral copy of the node table.
   logic signed [31:0] node_keys [NODES];
   logic signed [31:0] node_vals [NODES];
   int                 node_cnt = 0;

   node_req_type req_items[$];
   node_rsp_type predicted_rsps[$];
   node_req_type cur_req;
   node_rsp_type want_rsp;
   node_rsp_type got_rsp;
   int        total_items = 0;
   int        accepted_cnt = 0;
   int        error_cnt = 0;
   int        cycle_cnt = 0;

   sorted_table_linear_interpolator #(
      .MAX_NODES(NODES)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
   end

   // Both sides run without gaps inside one window of the run.
   function automatic bit idle_now();
      if (cycle_cnt >= 30000 && cycle_cnt < 50000)
         return 1'b0;
      return $urandom_range(99) < 23;
   endfunction

   // Linear interpolation on one segment: multiply, truncating divide, then
   // saturate the sum to the 32-bit range.
   function automatic logic signed [31:0] interp_segment(
      input logic signed [31:0] k0, input logic signed [31:0] v0,
      input logic signed [31:0] k1, input logic signed [31:0] v1,
      input logic signed [31:0] key);
      longint    dv;
      longint    dk;
      longint    dp;
      longint    sum;
      bit        neg;
      bit [63:0] mag_v;
      bit [63:0] mag_k;
      bit [63:0] prod;
      bit [63:0] quo;
      dv = longint'(v1) - longint'(v0);
      dk = longint'(key) - longint'(k0);
      dp = longint'(k1) - longint'(k0);
      neg = (dv < 0) != (dk < 0);
      mag_v = (dv < 0) ? -dv : dv;
      mag_k = (dk < 0) ? -dk : dk;
      prod = mag_v * mag_k;
      quo = prod / 64'(dp);
      if (quo > (64'd1 << 40))
         quo = 64'd1 << 40;
      sum = longint'(v0) + (neg ? -longint'(quo) : longint'(quo));
      if (sum > SUM_MAX)
         sum = SUM_MAX;
      if (sum < SUM_MIN)
         sum = SUM_MIN;
      return sum[31:0];
   endfunction

   task automatic predict_response(input node_req_type r);
      node_rsp_type rsp;
      int        pos;
      int        seg;
      int        j;
      bit        found;
      rsp.value = '0;
      rsp.status = STAT_OK;
      if (r.kind == REQ_INSERT) begin
         pos = 0;
         while (pos < node_cnt && node_keys[pos] < r.key)
            pos++;
         if (pos < node_cnt && node_keys[pos] == r.key) begin
            rsp.status = STAT_DUP;
         end else if (node_cnt >= NODES) begin
            rsp.status = STAT_FULL;
         end else begin
            for (j = node_cnt; j > pos; j--) begin
               node_keys[j] = node_keys[j-1];
               node_vals[j] = node_vals[j-1];
            end
            node_keys[pos] = r.key;
            node_vals[pos] = r.value;
            node_cnt++;
         end
      end else if (node_cnt == 0) begin
         rsp.status = STAT_EMPTY;
         rsp.value = VAL_MIN;
      end else if (node_cnt == 1) begin
         rsp.value = node_vals[0];
      end else begin
         // Keys past the last node fall back on the last segment.
         seg = node_cnt - 2;
         found = 1'b0;
         for (j = 1; j < node_cnt && !found; j++) begin
            if (r.key < node_keys[j]) begin
               seg = j - 1;
               found = 1'b1;
            end
         end
         rsp.value = interp_segment(node_keys[seg], node_vals[seg],
                                    node_keys[seg+1], node_vals[seg+1], r.key);
      end
      rsp.count = node_cnt[COUNT_W-1:0];
      predicted_rsps.insert(predicted_rsps.size(), rsp);
   endtask

   function automatic void add_req(input logic kind, input logic signed [31:0] key,
                                   input logic signed [31:0] value);
      node_req_type r;
      r.kind = kind;
      r.key = key;
      r.value = value;
      req_items.insert(req_items.size(), r);
   endfunction

   function automatic logic signed [31:0] rand_word();
      case ($urandom_range(9))
         0: return VAL_MAX;
         1: return VAL_MIN;
         2: return '0;
         default: return $urandom;
      endcase
   endfunction

   // Request driver.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_response(cur_req);
            accepted_cnt++;
         end
         if (!req_tvalid || req_tready) begin
            if (req_items.size() != 0 && !idle_now()) begin
               cur_req = req_items.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= {cur_req.value, cur_req.key};
               req_tuser <= cur_req.kind;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Response monitor.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got_rsp.value = rsp_tdata[31:0];
            got_rsp.status = rsp_tdata[33:32];
            got_rsp.count = rsp_tdata[38:34];
            if (predicted_rsps.size() == 0) begin
               $display("%0t: unexpected beat: value %h status %0d count %0d",
                        $time, got_rsp.value, got_rsp.status, got_rsp.count);
               error_cnt++;
            end else begin
               want_rsp = predicted_rsps.pop_front();
               if (got_rsp.value !== want_rsp.value || got_rsp.status !== want_rsp.status
                   || got_rsp.count !== want_rsp.count) begin
                  $display("%0t: expected %h/%0d/%0d, got %h/%0d/%0d (value/status/count)",
                           $time, want_rsp.value, want_rsp.status, want_rsp.count,
                           got_rsp.value, got_rsp.status, got_rsp.count);
                  error_cnt++;
               end
            end
         end
         rsp_tready <= !idle_now();
      end
   end

   initial begin
      logic signed [31:0] known_keys[$];
      int                 grid[11];
      int                 i;
      int                 k;
      int                 tmp;
      logic signed [31:0] key;

      // Empty table, single node, duplicate, then append and prepend.
      add_req(REQ_QUERY, '0, '0);
      add_req(REQ_INSERT, '0, 32'sh0064_0000);
      add_req(REQ_QUERY, 32'sh1234_5678, '0);
      add_req(REQ_INSERT, '0, -32'sd1);
      add_req(REQ_INSERT, 32'sd1, VAL_MAX);
      // Steep first segment: both ends extrapolate far past the 32-bit range.
      add_req(REQ_QUERY, VAL_MIN, '0);
      add_req(REQ_QUERY, VAL_MAX, -32'sd1);
      add_req(REQ_INSERT, VAL_MIN, VAL_MIN);
      add_req(REQ_INSERT, VAL_MAX, '0);
      add_req(REQ_INSERT, 32'sh0001_0000, -32'sh0005_0000);
      add_req(REQ_QUERY, '0, '0);
      add_req(REQ_QUERY, 32'sh0000_8000, '0);
      add_req(REQ_QUERY, VAL_MAX, '0);
      known_keys = '{32'sd0, 32'sd1, VAL_MIN, VAL_MAX, 32'sh0001_0000};

      // Fill the table in shuffled key order so inserts land at every place.
      for (i = 0; i < 11; i++)
         grid[i] = (i - 6) * 16777216 + int'($urandom_range(1 << 23, 1 << 20));
      for (i = 10; i > 0; i--) begin
         k = $urandom_range(i);
         tmp = grid[i];
         grid[i] = grid[k];
         grid[k] = tmp;
      end
      for (i = 0; i < 11; i++) begin
         add_req(REQ_INSERT, grid[i], rand_word());
         known_keys.insert(known_keys.size(), grid[i]);
      end
      add_req(REQ_INSERT, 32'sh0001_0000, '0);
      add_req(REQ_INSERT, 32'sh0aaa_aaaa, VAL_MAX);

      // The table stays full from here, so most beats are queries.
      for (i = 0; i < RANDOM_ITEMS; i++) begin
         if ($urandom_range(99) < 12) begin
            if ($urandom_range(1) == 0)
               key = known_keys[$urandom_range(known_keys.size() - 1)];
            else
               key = $urandom;
            add_req(REQ_INSERT, key, rand_word());
         end else begin
            case ($urandom_range(2))
               0: key = $urandom;
               1: key = known_keys[$urandom_range(known_keys.size() - 1)]
                        + int'($urandom_range(511)) - 256;
               default: key = known_keys[$urandom_range(known_keys.size() - 1)];
            endcase
            add_req(REQ_QUERY, key, $urandom);
         end
      end
      total_items = req_items.size();

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      while (accepted_cnt < total_items || predicted_rsps.size() != 0)
         @(posedge clock);
      repeat (200) @(posedge clock);
      if (error_cnt == 0 && predicted_rsps.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

   initial begin
      #10_000_000;
      $display("FAIL");
      $finish;
   end

endmodule
